@@ design/bpcc_pkg.sv @@
// Package for the binned PID confusion counter.
// Holds sizes, field widths, state and status codes and species lookup.
// No dependencies.
package bpcc_pkg;

  localparam int MOM_BINS     = 15;
  localparam int THETA_BINS   = 10;
  localparam int PHI_BINS     = 12;
  localparam int COUNT_WIDTH  = 32;
  localparam int NUM_SPECIES  = 4;
  localparam int NUM_OUTCOMES = 5;
  localparam int OUT_WIDTH    = 32;

  localparam int ROWS    = MOM_BINS * THETA_BINS * PHI_BINS * NUM_SPECIES;
  localparam int ADDR_W  = $clog2(ROWS);
  localparam int ROW_W   = COUNT_WIDTH * NUM_OUTCOMES;
  localparam int QB      = 4;                 // quotient bits per axis
  localparam int DW      = 25;                // signed difference width
  localparam int CW      = DW - 1 + QB;       // divider compare width
  localparam int IN_W    = 112;
  localparam int OUT_W   = 168;
  localparam int CFG_W   = 23;
  localparam int CFG_IDX_W = 3;

  localparam logic [2:0] OUTC_FAILED = 3'd4;

  typedef enum logic [1:0] {
    ST_COUNTED   = 2'd0,
    ST_UNTRACKED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_READ      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_MOM_LOW     = 3'd0,
    CFG_MOM_WIDTH   = 3'd1,
    CFG_THETA_LOW   = 3'd2,
    CFG_THETA_WIDTH = 3'd3,
    CFG_PHI_LOW     = 3'd4,
    CFG_PHI_WIDTH   = 3'd5,
    CFG_PHOTON_MIN  = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BIN_LD,
    S_BIN_DIV,
    S_ADDR,
    S_READ,
    S_MOD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] idx;
  } species_t;

  function automatic species_t species_of(input logic signed [13:0] code);
    species_t s;
    s.vld = 1'b1;
    s.idx = 2'd0;
    case (code)
      14'sd11:   s.idx = 2'd0;
      14'sd211:  s.idx = 2'd1;
      14'sd321:  s.idx = 2'd2;
      14'sd2212: s.idx = 2'd3;
      default:   s.vld = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic [QB:0] axis_bins(input logic [1:0] axis);
    logic [QB:0] b;
    case (axis)
      2'd0:    b = (QB+1)'(MOM_BINS);
      2'd1:    b = (QB+1)'(THETA_BINS);
      default: b = (QB+1)'(PHI_BINS);
    endcase
    return b;
  endfunction

endpackage

@@ design/binned_pid_confusion_counter.sv @@
// Binned PID confusion counter: top level, control and binning divider.
// Depends on bpcc_pkg and bpcc_ram.
//
// Usage:
// in_* carries one request: an accumulate (a track record) or a read of one
// cell. out_* returns exactly one result per request: a status and, for a
// read, the five counters of the cell and species. cfg_* writes the binning
// edges, widths and photon threshold; write only while the block is idle.
// Sequence: an accepted accumulate runs its three axes through a shared
// shift-subtract divider (load and range check, then one quotient bit a
// cycle), then address, memory read, read-modify-write and result load; an
// out-of-range axis goes straight to the result load. A read skips the
// divider; an untracked species or an out-of-range read cell goes straight
// to the result load. Only one request is in work at a time: the next is
// accepted once the result has loaded and the block is idle again.
// Reset: rst_n clears control state, restores the register defaults and
// starts a clearing pass over all 7200 counter rows, one row per cycle, during
// which in_tready stays low.
// Stall: a result waits in the output register while out_tready is low;
// the next request may be accepted and worked on meanwhile and is held in
// the done state until the output register is free.
module binned_pid_confusion_counter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // operation, true_code, reco_code, photon_count, momentum_mev, theta_urad,
  // phi_urad, cell_mom_bin, cell_theta_bin, cell_phi_bin, cell_species
  input  logic [bpcc_pkg::IN_W-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status, count_as_electron, count_as_pion, count_as_kaon,
  // count_as_proton, count_failed, zero pad
  output logic [bpcc_pkg::OUT_W-1:0]     out_tdata,
  input  logic                           cfg_we,
  input  logic [bpcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpcc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = bpcc_pkg::ADDR_W;
  localparam int QB = bpcc_pkg::QB;
  localparam int DW = bpcc_pkg::DW;
  localparam int CW = bpcc_pkg::CW;
  localparam int CWD = bpcc_pkg::COUNT_WIDTH;

  // configuration
  logic [15:0]        mom_low_r, mom_width_r;
  logic [21:0]        theta_low_r, theta_width_r;
  logic signed [22:0] phi_low_r;
  logic [22:0]        phi_width_r;
  logic [7:0]         photon_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mom_low_r     <= 16'd100;
      mom_width_r   <= 16'd1000;
      theta_low_r   <= 22'd2700000;
      theta_width_r <= 22'd40000;
      phi_low_r     <= -23'sd3141593;
      phi_width_r   <= 23'd523599;
      photon_min_r  <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpcc_pkg::CFG_MOM_LOW:     mom_low_r     <= cfg_data[15:0];
        bpcc_pkg::CFG_MOM_WIDTH:   mom_width_r   <= cfg_data[15:0];
        bpcc_pkg::CFG_THETA_LOW:   theta_low_r   <= cfg_data[21:0];
        bpcc_pkg::CFG_THETA_WIDTH: theta_width_r <= cfg_data[21:0];
        bpcc_pkg::CFG_PHI_LOW:     phi_low_r     <= $signed(cfg_data);
        bpcc_pkg::CFG_PHI_WIDTH:   phi_width_r   <= cfg_data;
        bpcc_pkg::CFG_PHOTON_MIN:  photon_min_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic                in_op;
  logic signed [13:0]  in_true, in_reco;
  logic [7:0]          in_photon;
  logic [15:0]         in_mom;
  logic [21:0]         in_theta;
  logic signed [22:0]  in_phi;
  logic [3:0]          in_cmb, in_ctb, in_cpb;
  logic [1:0]          in_csp;

  assign in_op     = in_tdata[0];
  assign in_true   = $signed(in_tdata[14:1]);
  assign in_reco   = $signed(in_tdata[28:15]);
  assign in_photon = in_tdata[36:29];
  assign in_mom    = in_tdata[52:37];
  assign in_theta  = in_tdata[74:53];
  assign in_phi    = $signed(in_tdata[97:75]);
  assign in_cmb    = in_tdata[101:98];
  assign in_ctb    = in_tdata[105:102];
  assign in_cpb    = in_tdata[109:106];
  assign in_csp    = in_tdata[111:110];

  // state
  bpcc_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic                op_r, op_nxt;
  logic [1:0]          sp_r, sp_nxt;
  logic [2:0]          outc_r, outc_nxt;
  logic                outc_vld_r, outc_vld_nxt;
  logic [15:0]         mom_r, mom_nxt;
  logic [21:0]         theta_r, theta_nxt;
  logic signed [22:0]  phi_r, phi_nxt;
  logic [1:0]          axis_r, axis_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [DW-2:0]       rem_r, rem_nxt;
  logic [22:0]         div_r, div_nxt;
  logic [QB-1:0]       q_r, q_nxt;
  logic [QB-1:0]       mb_r, mb_nxt, tb_r, tb_nxt, pb_r, pb_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  bpcc_pkg::status_t   status_r, status_nxt;
  logic [bpcc_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                out_valid_r, out_valid_nxt;
  bpcc_pkg::status_t   out_status_r, out_status_nxt;
  logic [bpcc_pkg::ROW_W-1:0] out_row_r, out_row_nxt;

  // memory
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [bpcc_pkg::ROW_W-1:0] ram_wdata;
  logic [bpcc_pkg::ROW_W-1:0] ram_rdata;

  bpcc_ram #(
    .WIDTH (bpcc_pkg::ROW_W),
    .DEPTH (bpcc_pkg::ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpcc_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    sp_r         <= sp_nxt;
    outc_r       <= outc_nxt;
    outc_vld_r   <= outc_vld_nxt;
    mom_r        <= mom_nxt;
    theta_r      <= theta_nxt;
    phi_r        <= phi_nxt;
    axis_r       <= axis_nxt;
    step_r       <= step_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    q_r          <= q_nxt;
    mb_r         <= mb_nxt;
    tb_r         <= tb_nxt;
    pb_r         <= pb_nxt;
    addr_r       <= addr_nxt;
    status_r     <= status_nxt;
    row_r        <= row_nxt;
    out_status_r <= out_status_nxt;
    out_row_r    <= out_row_nxt;
  end

  // datapath helpers
  bpcc_pkg::species_t in_true_sp, in_reco_sp;
  logic signed [DW-1:0] diff;
  logic [22:0]          width_sel;
  logic [CW-1:0]        shifted;
  logic [QB-1:0]        q_new;
  logic [CWD-1:0]       lane;
  logic [bpcc_pkg::ROW_W-1:0] row_mod;

  assign in_true_sp = bpcc_pkg::species_of(in_true);
  assign in_reco_sp = bpcc_pkg::species_of(in_reco);

  always_comb begin
    case (axis_r)
      2'd0: begin
        diff      = $signed(DW'(mom_r)) - $signed(DW'(mom_low_r));
        width_sel = 23'(mom_width_r);
      end
      2'd1: begin
        diff      = $signed(DW'(theta_r)) - $signed(DW'(theta_low_r));
        width_sel = 23'(theta_width_r);
      end
      default: begin
        diff      = DW'(phi_r) - DW'(phi_low_r);
        width_sel = phi_width_r;
      end
    endcase
  end

  assign shifted = CW'(div_r) << step_r;
  always_comb begin
    q_new = q_r;
    q_new[step_r] = (CW'(rem_r) >= shifted);
  end

  always_comb begin
    lane    = ram_rdata[outc_r*CWD +: CWD];
    row_mod = ram_rdata;
    if (lane != '1) begin
      row_mod[outc_r*CWD +: CWD] = lane + CWD'(1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    op_nxt         = op_r;
    sp_nxt         = sp_r;
    outc_nxt       = outc_r;
    outc_vld_nxt   = outc_vld_r;
    mom_nxt        = mom_r;
    theta_nxt      = theta_r;
    phi_nxt        = phi_r;
    axis_nxt       = axis_r;
    step_nxt       = step_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    q_nxt          = q_r;
    mb_nxt         = mb_r;
    tb_nxt         = tb_r;
    pb_nxt         = pb_r;
    addr_nxt       = addr_r;
    status_nxt     = status_r;
    row_nxt        = row_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_row_nxt    = out_row_r;
    in_tready      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = row_mod;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bpcc_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(bpcc_pkg::ROWS - 1)) begin
          state_nxt = bpcc_pkg::S_IDLE;
        end
      end
      bpcc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        row_nxt   = '0;
        if (in_tvalid) begin
          op_nxt    = in_op;
          mom_nxt   = in_mom;
          theta_nxt = in_theta;
          phi_nxt   = in_phi;
          axis_nxt  = 2'd0;
          if (in_photon < photon_min_r) begin
            outc_nxt     = bpcc_pkg::OUTC_FAILED;
            outc_vld_nxt = 1'b1;
          end else begin
            outc_nxt     = 3'(in_reco_sp.idx);
            outc_vld_nxt = in_reco_sp.vld;
          end
          if (in_op) begin
            mb_nxt = in_cmb;
            tb_nxt = in_ctb;
            pb_nxt = in_cpb;
            sp_nxt = in_csp;
            if (5'(in_cmb) >= 5'(bpcc_pkg::MOM_BINS) ||
                5'(in_ctb) >= 5'(bpcc_pkg::THETA_BINS) ||
                5'(in_cpb) >= 5'(bpcc_pkg::PHI_BINS)) begin
              status_nxt = bpcc_pkg::ST_RANGE;
              state_nxt  = bpcc_pkg::S_DONE;
            end else begin
              status_nxt = bpcc_pkg::ST_READ;
              state_nxt  = bpcc_pkg::S_ADDR;
            end
          end else begin
            sp_nxt = in_true_sp.idx;
            if (!in_true_sp.vld) begin
              status_nxt = bpcc_pkg::ST_UNTRACKED;
              state_nxt  = bpcc_pkg::S_DONE;
            end else begin
              status_nxt = bpcc_pkg::ST_COUNTED;
              state_nxt  = bpcc_pkg::S_BIN_LD;
            end
          end
        end
      end
      bpcc_pkg::S_BIN_LD: begin
        rem_nxt  = diff[DW-2:0];
        div_nxt  = width_sel;
        q_nxt    = '0;
        step_nxt = 2'(QB - 1);
        if (width_sel == '0 || diff < 0 ||
            CW'(diff[DW-2:0]) >= (CW'(width_sel) << QB)) begin
          status_nxt = bpcc_pkg::ST_RANGE;
          state_nxt  = bpcc_pkg::S_DONE;
        end else begin
          state_nxt = bpcc_pkg::S_BIN_DIV;
        end
      end
      bpcc_pkg::S_BIN_DIV: begin
        q_nxt    = q_new;
        step_nxt = step_r - 2'd1;
        if (q_new[step_r]) begin
          rem_nxt = rem_r - shifted[DW-2:0];
        end
        if (step_r == 2'd0) begin
          if ((QB+1)'(q_new) >= bpcc_pkg::axis_bins(axis_r)) begin
            status_nxt = bpcc_pkg::ST_RANGE;
            state_nxt  = bpcc_pkg::S_DONE;
          end else begin
            case (axis_r)
              2'd0:    mb_nxt = q_new;
              2'd1:    tb_nxt = q_new;
              default: pb_nxt = q_new;
            endcase
            if (axis_r == 2'd2) begin
              state_nxt = bpcc_pkg::S_ADDR;
            end else begin
              axis_nxt  = axis_r + 2'd1;
              state_nxt = bpcc_pkg::S_BIN_LD;
            end
          end
        end
      end
      bpcc_pkg::S_ADDR: begin
        addr_nxt = AW'(((32'(mb_r) * bpcc_pkg::THETA_BINS + 32'(tb_r))
                         * bpcc_pkg::PHI_BINS + 32'(pb_r))
                        * bpcc_pkg::NUM_SPECIES + 32'(sp_r));
        state_nxt = bpcc_pkg::S_READ;
      end
      bpcc_pkg::S_READ: begin
        state_nxt = bpcc_pkg::S_MOD;
      end
      bpcc_pkg::S_MOD: begin
        if (op_r) begin
          row_nxt = ram_rdata;
        end else begin
          ram_we = outc_vld_r;
        end
        state_nxt = bpcc_pkg::S_DONE;
      end
      bpcc_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_row_nxt    = (status_r == bpcc_pkg::ST_READ) ? row_r : '0;
          state_nxt      = bpcc_pkg::S_IDLE;
        end
      end
      default: state_nxt = bpcc_pkg::S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = bpcc_pkg::OUT_W'({out_row_r, out_status_r});

  // checks
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == bpcc_pkg::S_CLEAR || state_r == bpcc_pkg::S_MOD))
    else $error("memory write outside clear or update");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpcc_pkg::S_CLEAR |-> !in_tready)
    else $error("request accepted during clearing pass");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bpcc_pkg::S_DONE))
    else $error("result loaded outside done state");

  a_zero_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != bpcc_pkg::ST_READ |-> out_row_r == '0)
    else $error("nonzero counts on non-read result");

endmodule

@@ design/bpcc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bpcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/binned_pid_confusion_counter_chk.sv @@
// Checker for the binned PID confusion counter: watches the request, result
// and register-write ports, predicts each result and compares it field by field.
// Depends on bpcc_pkg for status codes and register indexes.
module binned_pid_confusion_counter_chk (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [167:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [22:0]  cfg_data,
  output int           errors,
  output int           pending
);

  localparam int NCELL = 15 * 10 * 12 * 4 * 5;

  typedef struct packed {
    bpcc_pkg::status_t st;
    logic [4:0][31:0]  cnt;
  } tally_t;

  int unsigned  counters [NCELL];
  tally_t       owed [$];
  logic [15:0]  r_mom_low, r_mom_width;
  logic [21:0]  r_theta_low, r_theta_width;
  logic [22:0]  r_phi_low, r_phi_width;
  logic [7:0]   r_photon_min;

  function automatic int species_idx(logic signed [13:0] code);
    case (code)
      14'sd11:   return 0;
      14'sd211:  return 1;
      14'sd321:  return 2;
      14'sd2212: return 3;
      default:   return -1;
    endcase
  endfunction

  function automatic bit axis_bin(longint x, longint lo, longint w, int n, output int b);
    longint q;
    b = 0;
    if (w == 0 || x < lo) return 1'b0;
    q = (x - lo) / w;
    b = int'(q);
    return q < n;
  endfunction

  function automatic tally_t tally(logic [111:0] d);
    tally_t r;
    int mb, tb, pb, sp, oc, base;
    bit ok;
    r.st = bpcc_pkg::ST_COUNTED;
    r.cnt = '0;
    if (d[0]) begin
      mb = d[101:98];
      tb = d[105:102];
      pb = d[109:106];
      sp = d[111:110];
      if (mb >= 15 || tb >= 10 || pb >= 12) begin
        r.st = bpcc_pkg::ST_RANGE;
        return r;
      end
      base = (((mb * 10 + tb) * 12 + pb) * 4 + sp) * 5;
      r.st = bpcc_pkg::ST_READ;
      for (int j = 0; j < 5; j++) r.cnt[j] = counters[base + j];
      return r;
    end
    sp = species_idx(d[14:1]);
    if (sp < 0) begin
      r.st = bpcc_pkg::ST_UNTRACKED;
      return r;
    end
    ok = axis_bin(longint'(d[52:37]), longint'(r_mom_low), longint'(r_mom_width), 15, mb);
    if (ok) ok = axis_bin(longint'(d[74:53]), longint'(r_theta_low),
                          longint'(r_theta_width), 10, tb);
    if (ok) ok = axis_bin(longint'($signed(d[97:75])), longint'($signed(r_phi_low)),
                          longint'(r_phi_width), 12, pb);
    if (!ok) begin
      r.st = bpcc_pkg::ST_RANGE;
      return r;
    end
    base = (((mb * 10 + tb) * 12 + pb) * 4 + sp) * 5;
    oc = (d[36:29] < r_photon_min) ? 4 : species_idx(d[28:15]);
    if (oc >= 0 && counters[base + oc] != 32'hFFFF_FFFF) counters[base + oc]++;
    return r;
  endfunction

  always @(posedge clk) begin
    tally_t e;
    if (!rst_n) begin
      for (int k = 0; k < NCELL; k++) counters[k] = 0;
      owed.delete();
      r_mom_low = 16'd100;
      r_mom_width = 16'd1000;
      r_theta_low = 22'd2700000;
      r_theta_width = 22'd40000;
      r_phi_low = 23'(-3141593);
      r_phi_width = 23'd523599;
      r_photon_min = 8'd4;
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed.size() == 0) begin
          $display("%0t: result with none owed: actual %h", $time, out_tdata);
          errors++;
        end else begin
          e = owed.pop_front();
          if (out_tdata[1:0] !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, out_tdata[1:0]);
            errors++;
          end
          for (int j = 0; j < 5; j++)
            if (out_tdata[2 + 32*j +: 32] !== e.cnt[j]) begin
              $display("%0t: counter %0d expected %0d actual %0d", $time, j, e.cnt[j],
                       out_tdata[2 + 32*j +: 32]);
              errors++;
            end
        end
      end
      if (in_tvalid && in_tready) owed.push_back(tally(in_tdata));
      if (cfg_we) begin
        case (cfg_index)
          bpcc_pkg::CFG_MOM_LOW:     r_mom_low = cfg_data[15:0];
          bpcc_pkg::CFG_MOM_WIDTH:   r_mom_width = cfg_data[15:0];
          bpcc_pkg::CFG_THETA_LOW:   r_theta_low = cfg_data[21:0];
          bpcc_pkg::CFG_THETA_WIDTH: r_theta_width = cfg_data[21:0];
          bpcc_pkg::CFG_PHI_LOW:     r_phi_low = cfg_data;
          bpcc_pkg::CFG_PHI_WIDTH:   r_phi_width = cfg_data;
          bpcc_pkg::CFG_PHOTON_MIN:  r_photon_min = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    pending = owed.size();
  end

  initial errors = 0;
endmodule

@@ tb/binned_pid_confusion_counter_tb.sv @@
// Top of the confusion counter bench: clock, reset, register phases, track and
// read requests with random idling, and the verdict.
// Depends on bpcc_pkg, the block and binned_pid_confusion_counter_chk.
module binned_pid_confusion_counter_tb;

  localparam logic [2:0] CFG_NONE = 3'd7;
  localparam int WATCHDOG = 50000;
  localparam logic signed [13:0] CODES [4] = '{14'sd11, 14'sd211, 14'sd321, 14'sd2212};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [22:0]  cfg_data = '0;
  int           errors, pending;
  int           idle_cycles = 0;
  bit           tx_burst = 0, rx_burst = 0, hold_req = 0;
  longint       m_lo = 100, m_w = 1000, t_lo = 2700000, t_w = 40000;
  longint       p_lo = -3141593, p_w = 523599;
  logic [13:0]  recent [$];

  binned_pid_confusion_counter uut (.*);

  binned_pid_confusion_counter_chk chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int g;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        g = rx_burst ? 0 : $urandom_range(0, 7);
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send(logic [111:0] d);
    int g;
    g = tx_burst ? 0 : $urandom_range(0, 7);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [111:0] trk(logic [13:0] tru, logic [13:0] reco, logic [7:0] ph,
                                       longint mom, longint th, longint phi);
    return {14'd0, 23'(phi), 22'(th), 16'(mom), ph, reco, tru, 1'b0};
  endfunction

  function automatic logic [111:0] rd(int mb, int tb, int pb, int sp);
    return {2'(sp), 4'(pb), 4'(tb), 4'(mb), 97'd0, 1'b1};
  endfunction

  function automatic longint clip(longint v, longint hi);
    return v > hi ? hi : v;
  endfunction

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_cfg(longint ml, longint mw, longint tl, longint tw, longint pl,
                         longint pw, longint pm);
    longint v [7];
    v = '{ml, mw, tl, tw, pl, pw, pm};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= 23'(v[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_lo = ml & 16'hFFFF;
    m_w = mw & 16'hFFFF;
    t_lo = tl & 22'h3FFFFF;
    t_w = tw & 22'h3FFFFF;
    p_lo = longint'($signed(23'(pl)));
    p_w = pw & 23'h7FFFFF;
  endtask

  task automatic run_random(int n);
    int r, mb, tb, pb, sp;
    logic [13:0] c;
    logic [13:0] reco;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        if (recent.size() > 0 && r < 15) begin
          c = recent[$urandom_range(0, recent.size() - 1)];
          send(rd(c[3:0], c[7:4], c[11:8], c[13:12]));
        end else
          send(rd($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 3)));
      end else if (r < 28) begin
        send(112'({$urandom, $urandom, $urandom, $urandom}) & ~112'd1);
      end else begin
        mb = $urandom_range(0, 99) < 95 ? $urandom_range(0, 14) : 15;
        tb = $urandom_range(0, 99) < 95 ? $urandom_range(0, 9) : 10;
        pb = $urandom_range(0, 99) < 95 ? $urandom_range(0, 11) : 12;
        sp = $urandom_range(0, 3);
        reco = $urandom_range(0, 99) < 80 ? CODES[$urandom_range(0, 3)] : 14'($urandom);
        send(trk(CODES[sp], reco, 8'($urandom),
                 clip(m_lo + mb * m_w + (m_w > 0 ? $urandom % m_w : 0), 65535),
                 clip(t_lo + tb * t_w + (t_w > 0 ? $urandom % t_w : 0), 4194303),
                 clip(p_lo + pb * p_w + (p_w > 0 ? $urandom % p_w : 0), 4194303)));
        recent.push_back({2'(sp), 4'(pb), 4'(tb), 4'(mb)});
        if (recent.size() > 16) void'(recent.pop_front());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!in_tready);

    send(rd(0, 0, 0, 0));
    send(trk(14'sd13, 14'sd11, 50, 600, 2750000, 0));
    send(trk(-14'sd8192, 14'sd11, 50, 600, 2750000, 0));
    send(trk(14'sd8191, 14'sd11, 50, 600, 2750000, 0));
    for (int s = 0; s < 4; s++) begin
      send(trk(CODES[s], CODES[s], 3, 600, 2750000, 0));
      send(trk(CODES[s], CODES[3 - s], 255, 600, 2750000, 0));
    end
    send(trk(CODES[0], -14'sd8192, 4, 600, 2750000, 0));
    send(trk(CODES[1], CODES[1], 10, 50, 2750000, 0));
    send(trk(CODES[1], CODES[1], 10, 65535, 2750000, 0));
    send(trk(CODES[2], CODES[2], 10, 14099, 0, -3141593));
    send(trk(CODES[2], CODES[2], 10, 14099, 4194303, 0));
    send(trk(CODES[3], CODES[3], 10, 100, 2700000, -3141593));
    send(trk(CODES[3], CODES[3], 10, 100, 2700000, 4194303));
    send(trk(CODES[3], CODES[3], 10, 100, 2700000, -4194304));
    send(rd(0, 0, 0, 3));
    send(rd(0, 1, 6, 0));
    send(rd(15, 15, 15, 3));
    send(rd(14, 9, 11, 1));
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      set_cfg($urandom_range(0, 5000), $urandom_range(1, 4000), $urandom_range(0, 2000000),
              $urandom_range(1, 100000), -longint'($urandom_range(0, 3141593)),
              $urandom_range(1, 600000), $urandom_range(0, 255));
      tx_burst = ph == 2 || ph == 5;
      rx_burst = ph == 3 || ph == 5;
      if (ph == 1) hold_req = 1;
      run_random(200);
      settle();
    end
    tx_burst = 0;
    rx_burst = 0;

    set_cfg(0, 1, 0, 1, -3141593, 1, 0);
    run_random(80);
    settle();
    set_cfg(23'h7FFFFF, 65535, 3141593, 3141593, 3141593, 6283186, 255);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NONE;
    cfg_data <= 23'h7FFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    run_random(80);
    settle();
    set_cfg(100, 0, 2700000, 0, -3141593, 0, 4);
    run_random(40);
    settle();
    set_cfg(100, 1000, 2700000, 40000, -3141593, 523599, 4);
    run_random(100);
    settle();

    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
